// ----- sv/sbfp_pkg.sv -----
package sbfp_pkg;

   // request operations
   localparam logic [1:0] OP_START     = 2'd0;
   localparam logic [1:0] OP_DATA      = 2'd1;
   localparam logic [1:0] OP_CHUNK_END = 2'd2;
   localparam logic [1:0] OP_READ_USER = 2'd3;

   // result status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_NEED_MORE   = 3'd1;
   localparam logic [2:0] ST_COMPLETE    = 3'd2;
   localparam logic [2:0] ST_TOO_MANY    = 3'd3;
   localparam logic [2:0] ST_OVERFLOW    = 3'd4;
   localparam logic [2:0] ST_UNFINISHED  = 3'd5;
   localparam logic [2:0] ST_READ_DATA   = 3'd6;

   // register indexes (byte address is 4 * index)
   localparam logic [2:0] REG_FULL_MESSAGE_MODE = 3'd0;
   localparam logic [2:0] REG_FIXUP_FIELD_A     = 3'd1;
   localparam logic [2:0] REG_FIXUP_FIELD_B     = 3'd2;
   localparam logic [2:0] REG_USER_FIELD        = 3'd3;
   localparam logic [2:0] REG_LAST_FIELD        = 3'd4;
   localparam logic [2:0] REG_MAX_MESSAGE       = 3'd5;

   localparam logic [3:0] FIELD_INDEX_MAX = 4'd15;
   localparam logic [1:0] LENGTH_BYTES_LAST = 2'd3;

   typedef struct packed {
      logic        full_message_mode;
      logic [3:0]  fixup_field_a;
      logic [3:0]  fixup_field_b;
      logic [3:0]  user_field;
      logic [3:0]  last_field;
      logic [15:0] max_message;
   } cfg_type;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data_byte;
      logic [5:0] user_index;
   } req_item_type;

   typedef struct packed {
      logic [2:0] status;
      logic       forward_valid;
      logic [7:0] forward_byte;
      logic [7:0] user_byte;
      logic [6:0] user_length;
   } result_type;

   function automatic logic [3:0] field_advance(input logic [3:0] idx);
      return (idx == FIELD_INDEX_MAX) ? idx : idx + 4'd1;
   endfunction

endpackage

// ----- sv/ssh_blob_field_parser.sv -----
// SSH sign request field parser. Each transaction on the req_ side carries one operation
// (start, request byte, chunk end check, user name read) and yields exactly one transaction
// on the rsp_ side. One transaction is accepted per clock while the receiver keeps up; the
// accepting edge registers the item and the user name memory read, and a later step, taken
// when the result register is free, updates the parse state (length shift, 32-bit
// remaining-byte count, message count) and loads the result register. The user
// name memory holds USER_BYTES bytes and needs no clearing after reset; bytes that were never
// captured are never returned. Registers sit at byte address 4*index on the csr_ port and
// must only be written while no transaction is in flight.
module ssh_blob_field_parser #(
   parameter int USER_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // data_byte[7:0], user_index[13:8], zero pad
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // forward_byte[7:0], user_byte[15:8], user_length[22:16]
   output logic [3:0]  rsp_tuser,   // status[2:0], forward_valid[3]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   import sbfp_pkg::*;

   localparam int AW  = (USER_BYTES > 1) ? $clog2(USER_BYTES) : 1;
   localparam int UCW = $clog2(USER_BYTES + 1);

   cfg_type      cfg_ff;
   req_item_type item_ff;
   logic         item_valid_ff;
   result_type   result_ff;
   logic         rsp_valid_ff;

   result_type   result;
   logic         advance;
   logic         accept;
   logic         step;
   logic         csr_write;
   logic [2:0]   csr_index;
   logic         wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]   wr_data;
   logic [7:0]   rd_byte;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !item_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign step       = item_valid_ff && advance;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.full_message_mode <= 1'b0;
         cfg_ff.fixup_field_a     <= 4'd0;
         cfg_ff.fixup_field_b     <= 4'd0;
         cfg_ff.user_field        <= 4'd0;
         cfg_ff.last_field        <= 4'd15;
         cfg_ff.max_message       <= 16'hFFFF;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FULL_MESSAGE_MODE: cfg_ff.full_message_mode <= csr_pwdata[0];
            REG_FIXUP_FIELD_A:     cfg_ff.fixup_field_a     <= csr_pwdata[3:0];
            REG_FIXUP_FIELD_B:     cfg_ff.fixup_field_b     <= csr_pwdata[3:0];
            REG_USER_FIELD:        cfg_ff.user_field        <= csr_pwdata[3:0];
            REG_LAST_FIELD:        cfg_ff.last_field        <= csr_pwdata[3:0];
            REG_MAX_MESSAGE:       cfg_ff.max_message       <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_FULL_MESSAGE_MODE: csr_prdata = {31'd0, cfg_ff.full_message_mode};
         REG_FIXUP_FIELD_A:     csr_prdata = {28'd0, cfg_ff.fixup_field_a};
         REG_FIXUP_FIELD_B:     csr_prdata = {28'd0, cfg_ff.fixup_field_b};
         REG_USER_FIELD:        csr_prdata = {28'd0, cfg_ff.user_field};
         REG_LAST_FIELD:        csr_prdata = {28'd0, cfg_ff.last_field};
         REG_MAX_MESSAGE:       csr_prdata = {16'd0, cfg_ff.max_message};
         default:               csr_prdata = 32'd0;
      endcase
   end

   // input stage: hold the item while the result register is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (accept) begin
         item_valid_ff <= 1'b1;
      end else if (step) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.op         <= req_tuser;
         item_ff.data_byte  <= req_tdata[7:0];
         item_ff.user_index <= req_tdata[13:8];
      end
   end

   sbfp_user_ram #(
      .DEPTH (USER_BYTES),
      .AW    (AW)
   ) u_user_ram (
      .clock   (clock),
      .wr_en   (wr_en && step),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (AW'(req_tdata[13:8])),
      .rd_data (rd_byte)
   );

   sbfp_parse_core #(
      .USER_BYTES (USER_BYTES),
      .AW         (AW),
      .UCW        (UCW)
   ) u_parse_core (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .cfg     (cfg_ff),
      .item    (item_ff),
      .rd_byte (rd_byte),
      .result  (result),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // result register: load on step, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= step || (rsp_valid_ff && !rsp_tready);
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, result_ff.user_length, result_ff.user_byte,
                        result_ff.forward_byte};
   assign rsp_tuser  = {result_ff.forward_valid, result_ff.status};

endmodule

// ----- sv/sbfp_user_ram.sv -----
module sbfp_user_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // forward a byte written at the same edge it is read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data <= wr_data;
         end else begin
            rd_data <= mem[rd_addr];
         end
      end
   end

endmodule

// ----- sv/sbfp_parse_core.sv -----
module sbfp_parse_core #(
   parameter int USER_BYTES = 64,
   parameter int AW         = 6,
   parameter int UCW        = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  sbfp_pkg::cfg_type     cfg,
   input  sbfp_pkg::req_item_type item,
   input  logic [7:0]            rd_byte,
   output sbfp_pkg::result_type  result,
   output logic                  wr_en,
   output logic [AW-1:0]         wr_addr,
   output logic [7:0]            wr_data
);

   import sbfp_pkg::*;

   localparam int CW = (UCW > 6) ? UCW : 6;

   logic [3:0]     field_index_ff, field_index_in;
   logic           in_body_ff, in_body_in;
   logic [1:0]     len_count_ff, len_count_in;
   logic [31:0]    len_shift_ff, len_shift_in;
   logic [31:0]    remaining_ff, remaining_in;
   logic [UCW-1:0] user_count_ff, user_count_in;
   logic [15:0]    msg_count_ff, msg_count_in;
   logic           failed_ff, failed_in;

   logic           close_empty;
   logic [3:0]     field_index_c;
   logic           in_body_c;
   logic [2:0]     sticky;
   logic [31:0]    shifted;
   logic [31:0]    remaining_dec;
   logic           capture;

   always_comb begin
      close_empty   = in_body_ff && (remaining_ff == 32'd0);
      field_index_c = close_empty ? field_advance(field_index_ff) : field_index_ff;
      in_body_c     = close_empty ? 1'b0 : in_body_ff;
      sticky        = (field_index_ff >= cfg.last_field) ? ST_TOO_MANY : ST_OVERFLOW;
      shifted       = {len_shift_ff[23:0], item.data_byte};
      remaining_dec = remaining_ff - 32'd1;
      capture       = (field_index_c == cfg.user_field)
                      && (user_count_ff < UCW'(USER_BYTES));
   end

   always_comb begin
      field_index_in = field_index_ff;
      in_body_in     = in_body_ff;
      len_count_in   = len_count_ff;
      len_shift_in   = len_shift_ff;
      remaining_in   = remaining_ff;
      user_count_in  = user_count_ff;
      msg_count_in   = msg_count_ff;
      failed_in      = failed_ff;
      wr_en          = 1'b0;
      result.status        = ST_OK;
      result.forward_valid = 1'b0;
      result.user_byte     = 8'd0;

      unique case (item.op)
         OP_START: begin
            field_index_in = 4'd0;
            in_body_in     = 1'b0;
            len_count_in   = 2'd0;
            len_shift_in   = 32'd0;
            remaining_in   = 32'd0;
            user_count_in  = '0;
            msg_count_in   = 16'd0;
            failed_in      = 1'b0;
         end
         OP_DATA: begin
            if (failed_ff) begin
               result.status = sticky;
            end else begin
               field_index_in = field_index_c;
               in_body_in     = in_body_c;
               if (field_index_c >= cfg.last_field) begin
                  failed_in     = 1'b1;
                  result.status = ST_TOO_MANY;
               end else if (cfg.full_message_mode && (msg_count_ff >= cfg.max_message)) begin
                  failed_in     = 1'b1;
                  result.status = ST_OVERFLOW;
               end else begin
                  result.forward_valid = 1'b1;
                  if (cfg.full_message_mode) begin
                     msg_count_in = msg_count_ff + 16'd1;
                  end
                  if (!in_body_c) begin
                     len_shift_in = shifted;
                     if (len_count_ff == LENGTH_BYTES_LAST) begin
                        len_count_in = 2'd0;
                        in_body_in   = 1'b1;
                        // the fixup wraps an all-ones length to an empty body
                        if ((field_index_c == cfg.fixup_field_a)
                            || (field_index_c == cfg.fixup_field_b)) begin
                           remaining_in = shifted + 32'd1;
                        end else begin
                           remaining_in = shifted;
                        end
                     end else begin
                        len_count_in = len_count_ff + 2'd1;
                     end
                  end else begin
                     if (capture) begin
                        wr_en         = 1'b1;
                        user_count_in = user_count_ff + UCW'(1);
                     end
                     remaining_in = remaining_dec;
                     if (remaining_dec == 32'd0) begin
                        in_body_in     = 1'b0;
                        field_index_in = field_advance(field_index_c);
                     end
                  end
               end
            end
         end
         OP_CHUNK_END: begin
            if (failed_ff) begin
               result.status = sticky;
            end else begin
               field_index_in = field_index_c;
               in_body_in     = in_body_c;
               if (field_index_c != cfg.last_field) begin
                  result.status = ST_NEED_MORE;
               end else if (in_body_c) begin
                  result.status = ST_UNFINISHED;
               end else begin
                  result.status = ST_COMPLETE;
               end
            end
         end
         OP_READ_USER: begin
            result.status = ST_READ_DATA;
            if (CW'(item.user_index) < CW'(user_count_ff)) begin
               result.user_byte = rd_byte;
            end
         end
         default: begin
         end
      endcase

      result.forward_byte = result.forward_valid ? item.data_byte : 8'd0;
      result.user_length  = 7'(user_count_in);
   end

   assign wr_addr = user_count_ff[AW-1:0];
   assign wr_data = item.data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_index_ff <= 4'd0;
         in_body_ff     <= 1'b0;
         len_count_ff   <= 2'd0;
         len_shift_ff   <= 32'd0;
         remaining_ff   <= 32'd0;
         user_count_ff  <= '0;
         msg_count_ff   <= 16'd0;
         failed_ff      <= 1'b0;
      end else if (step) begin
         field_index_ff <= field_index_in;
         in_body_ff     <= in_body_in;
         len_count_ff   <= len_count_in;
         len_shift_ff   <= len_shift_in;
         remaining_ff   <= remaining_in;
         user_count_ff  <= user_count_in;
         msg_count_ff   <= msg_count_in;
         failed_ff      <= failed_in;
      end
   end

endmodule

// ----- test/tb_top.sv -----
import sbfp_pkg::*;

// Tracks the parser state in step with the block and keeps one expected result per
// accepted request transaction, oldest first.
class parse_scoreboard;
   localparam int NAME_BYTES = 64;

   cfg_type     cfg;
   logic [3:0]  field_index;
   bit          in_body;
   logic [1:0]  len_count;
   logic [31:0] len_shift;
   logic [31:0] remaining;
   logic [6:0]  user_count;
   logic [7:0]  user_name [NAME_BYTES];
   logic [15:0] msg_count;
   bit          failed;
   result_type  expected_q [$];
   int          mismatches;

   function new();
      cfg.full_message_mode = 1'b0;
      cfg.fixup_field_a = 4'd0;
      cfg.fixup_field_b = 4'd0;
      cfg.user_field = 4'd0;
      cfg.last_field = 4'd15;
      cfg.max_message = 16'hFFFF;
      mismatches = 0;
      clear_parse();
   endfunction

   function void clear_parse();
      field_index = 4'd0;
      in_body = 1'b0;
      len_count = 2'd0;
      len_shift = 32'd0;
      remaining = 32'd0;
      user_count = 7'd0;
      msg_count = 16'd0;
      failed = 1'b0;
   endfunction

   function void advance_field();
      in_body = 1'b0;
      if (field_index != 4'd15) field_index = field_index + 4'd1;
   endfunction

   function void close_empty_body();
      if (in_body && remaining == 32'd0) advance_field();
   endfunction

   function logic [2:0] sticky_code();
      return (field_index >= cfg.last_field) ? ST_TOO_MANY : ST_OVERFLOW;
   endfunction

   function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
         REG_FULL_MESSAGE_MODE: cfg.full_message_mode = value[0];
         REG_FIXUP_FIELD_A:     cfg.fixup_field_a = value[3:0];
         REG_FIXUP_FIELD_B:     cfg.fixup_field_b = value[3:0];
         REG_USER_FIELD:        cfg.user_field = value[3:0];
         REG_LAST_FIELD:        cfg.last_field = value[3:0];
         REG_MAX_MESSAGE:       cfg.max_message = value[15:0];
         default: ;
      endcase
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   function void note_request(req_item_type item);
      result_type res;
      res = '0;
      res.status = ST_OK;
      case (item.op)
         OP_START: clear_parse();
         OP_DATA: begin
            if (failed) begin
               res.status = sticky_code();
            end else begin
               close_empty_body();
               if (field_index >= cfg.last_field) begin
                  failed = 1'b1;
                  res.status = ST_TOO_MANY;
               end else if (cfg.full_message_mode && msg_count >= cfg.max_message) begin
                  failed = 1'b1;
                  res.status = ST_OVERFLOW;
               end else begin
                  res.forward_valid = 1'b1;
                  res.forward_byte = item.data_byte;
                  if (cfg.full_message_mode) msg_count = msg_count + 16'd1;
                  if (!in_body) begin
                     len_shift = {len_shift[23:0], item.data_byte};
                     if (len_count == 2'd3) begin
                        len_count = 2'd0;
                        in_body = 1'b1;
                        remaining = len_shift;
                        // the fixup wraps an all-ones length to an empty field
                        if (field_index == cfg.fixup_field_a ||
                            field_index == cfg.fixup_field_b)
                           remaining = remaining + 32'd1;
                     end else begin
                        len_count = len_count + 2'd1;
                     end
                  end else begin
                     if (field_index == cfg.user_field && user_count < 7'(NAME_BYTES)) begin
                        user_name[user_count[5:0]] = item.data_byte;
                        user_count = user_count + 7'd1;
                     end
                     remaining = remaining - 32'd1;
                     if (remaining == 32'd0) advance_field();
                  end
               end
            end
         end
         OP_CHUNK_END: begin
            if (failed) begin
               res.status = sticky_code();
            end else begin
               close_empty_body();
               if (field_index != cfg.last_field) res.status = ST_NEED_MORE;
               else if (in_body) res.status = ST_UNFINISHED;
               else res.status = ST_COMPLETE;
            end
         end
         default: begin
            res.status = ST_READ_DATA;
            if ({1'b0, item.user_index} < user_count)
               res.user_byte = user_name[item.user_index];
         end
      endcase
      res.user_length = user_count;
      expected_q.push_back(res);
   endfunction

   function void check_result(result_type got);
      result_type want;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result: status=%0d fwd=%0d byte=%02h user_byte=%02h len=%0d",
                     got.status, got.forward_valid, got.forward_byte, got.user_byte,
                     got.user_length);
         return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch: expected status=%0d fwd=%0d byte=%02h user_byte=%02h len=%0d",
                     want.status, want.forward_valid, want.forward_byte, want.user_byte,
                     want.user_length);
            $display("          got      status=%0d fwd=%0d byte=%02h user_byte=%02h len=%0d",
                     got.status, got.forward_valid, got.forward_byte, got.user_byte,
                     got.user_length);
         end
      end
   endfunction
endclass

module tb_top;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = 16'd0;   // data_byte[7:0], user_index[13:8], zero pad
   logic [1:0]  req_tuser = 2'd0;    // op[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // forward_byte[7:0], user_byte[15:8], user_length[22:16]
   logic [3:0]  rsp_tuser;           // status[2:0], forward_valid[3]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = 5'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   parse_scoreboard sb;
   bit quiet = 1'b0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int items_sent = 0;

   ssh_blob_field_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #2 clock = ~clock;

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= 28);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result('{status: rsp_tuser[2:0], forward_valid: rsp_tuser[3],
                           forward_byte: rsp_tdata[7:0], user_byte: rsp_tdata[15:8],
                           user_length: rsp_tdata[22:16]});
   end

   task automatic send_req(input logic [1:0] op, input logic [7:0] b, input logic [5:0] ui);
      req_item_type item;
      item.op = op;
      item.data_byte = b;
      item.user_index = ui;
      while (!quiet && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {2'b00, ui, b};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(item);
      items_sent++;
   endtask

   // data byte with occasional checks, reads and restarts mixed in
   task automatic send_byte(input logic [7:0] b);
      case ($urandom_range(19))
         0: send_req(OP_CHUNK_END, 8'($urandom), 6'($urandom));
         1: send_req(OP_READ_USER, 8'($urandom), 6'($urandom));
         2: send_req(OP_READ_USER, 8'($urandom), 6'($urandom_range(7)));
         default: ;
      endcase
      if ($urandom_range(99) == 0) send_req(OP_START, 8'($urandom), 6'($urandom));
      send_req(OP_DATA, b, 6'($urandom));
   endtask

   task automatic send_request();
      int nfields;
      logic [31:0] len;
      logic [31:0] body;
      bit fix;
      send_req(OP_START, 8'($urandom), 6'($urandom));
      nfields = int'(sb.cfg.last_field);
      case ($urandom_range(7))
         0: nfields++;
         1: nfields = $urandom_range(nfields);
         default: ;
      endcase
      if (nfields == 0) nfields = 1;
      for (int f = 0; f < nfields; f++) begin
         fix = (f == int'(sb.cfg.fixup_field_a)) || (f == int'(sb.cfg.fixup_field_b));
         case ($urandom_range(19))
            0: len = fix ? 32'hFFFF_FFFF : 32'd0;
            1, 2: len = (f == int'(sb.cfg.user_field)) ? $urandom_range(60, 70)
                                                      : $urandom_range(8, 16);
            default: len = $urandom_range(5);
         endcase
         body = len + {31'd0, fix};
         for (int k = 0; k < 4; k++) send_byte(len[31 - 8 * k -: 8]);
         for (int k = 0; k < body; k++) send_byte(8'($urandom));
      end
      send_req(OP_CHUNK_END, 8'($urandom), 6'($urandom));
      repeat ($urandom_range(2)) send_req(OP_READ_USER, 8'($urandom), 6'($urandom_range(15)));
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.set_reg(idx, value);
      @(posedge clock);
   endtask

   // drop valid and drain every outstanding transaction
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int phase_end;
      cfg_type pick;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // two fields, fixups on fields 1 and 2, user name in field 0, 10-byte message
      csr_write(REG_FULL_MESSAGE_MODE, 32'd1);
      csr_write(REG_FIXUP_FIELD_A, 32'd1);
      csr_write(REG_FIXUP_FIELD_B, 32'd2);
      csr_write(REG_USER_FIELD, 32'd0);
      csr_write(REG_LAST_FIELD, 32'd2);
      csr_write(REG_MAX_MESSAGE, 32'd10);
      send_req(OP_READ_USER, 8'h00, 6'd0);
      send_req(OP_START, 8'hFF, 6'd63);
      send_req(OP_DATA, 8'h00, 6'd63);
      send_req(OP_DATA, 8'h00, 6'd0);
      send_req(OP_DATA, 8'h00, 6'd63);
      send_req(OP_DATA, 8'h02, 6'd0);
      send_req(OP_DATA, 8'h00, 6'd63);
      send_req(OP_DATA, 8'hFF, 6'd0);
      send_req(OP_READ_USER, 8'h00, 6'd1);
      // all-ones length on a fixup field wraps to an empty body
      send_req(OP_DATA, 8'hFF, 6'd0);
      send_req(OP_DATA, 8'hFF, 6'd0);
      send_req(OP_DATA, 8'hFF, 6'd0);
      send_req(OP_DATA, 8'hFF, 6'd0);
      send_req(OP_CHUNK_END, 8'h00, 6'd0);
      send_req(OP_DATA, 8'h5A, 6'd0);
      send_req(OP_CHUNK_END, 8'h00, 6'd0);
      wait_idle();
      csr_write(REG_MAX_MESSAGE, 32'd0);
      send_req(OP_START, 8'h00, 6'd0);
      send_req(OP_DATA, 8'h80, 6'd0);
      send_req(OP_CHUNK_END, 8'h00, 6'd0);
      wait_idle();
      csr_write(REG_FULL_MESSAGE_MODE, 32'd0);
      send_req(OP_START, 8'h00, 6'd0);
      send_req(OP_DATA, 8'h00, 6'd0);
      send_req(OP_DATA, 8'h00, 6'd0);
      send_req(OP_DATA, 8'h00, 6'd0);
      send_req(OP_DATA, 8'h05, 6'd0);
      send_req(OP_DATA, 8'hA5, 6'd0);
      // move the last field under an open body
      wait_idle();
      csr_write(REG_LAST_FIELD, 32'd0);
      send_req(OP_CHUNK_END, 8'h00, 6'd0);

      for (int phase = 0; phase < 7; phase++) begin
         wait_idle();
         pick.full_message_mode = phase[0];
         pick.fixup_field_a = 4'($urandom_range(15));
         pick.fixup_field_b = 4'($urandom_range(15));
         pick.user_field = 4'($urandom_range(3));
         pick.last_field = 4'($urandom_range(1, 5));
         pick.max_message = phase[0] ? 16'($urandom_range(30, 120))
                                     : 16'($urandom_range(65535));
         case (phase)
            0: pick = '{1'b0, 4'd0, 4'd15, 4'd0, 4'd15, 16'hFFFF};
            1: begin
               pick.fixup_field_a = 4'd15;
               pick.fixup_field_b = 4'd0;
               pick.user_field = 4'd15;
            end
            3: pick.max_message = 16'hFFFF;
            6: begin
               pick.user_field = 4'd0;
               pick.last_field = 4'd0;
               pick.max_message = 16'd0;
            end
            default: ;
         endcase
         csr_write(REG_FULL_MESSAGE_MODE, {31'd0, pick.full_message_mode});
         csr_write(REG_FIXUP_FIELD_A, {28'd0, pick.fixup_field_a});
         csr_write(REG_FIXUP_FIELD_B, {28'd0, pick.fixup_field_b});
         csr_write(REG_USER_FIELD, {28'd0, pick.user_field});
         csr_write(REG_LAST_FIELD, {28'd0, pick.last_field});
         csr_write(REG_MAX_MESSAGE, {16'd0, pick.max_message});
         if (phase == 2) hold_request = 1'b1;
         quiet = (phase == 4);
         phase_end = items_sent + ((phase == 6) ? 20 : 36);
         while (items_sent < phase_end) send_request();
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("tb_top failed");
      $finish;
   end
endmodule
